@@ sv/rgps_pkg.sv @@
// Shared constants and types for the rectangle gradient pixel shader.
// No dependencies; imported by rgps_div and rect_gradient_pixel_shader_core.
package rgps_pkg;

	// screen limits, pixels
	localparam int SCREEN_WIDTH  = 2048;
	localparam int SCREEN_HEIGHT = 2048;
	localparam int SCR_CW        = 14;	// holds any screen limit up to 8192

	// field widths
	localparam int COORD_W    = 11;
	localparam int POS_W      = 16;
	localparam int SIZE_W     = 15;
	localparam int RGB_W      = 24;
	localparam int ARGB_W     = 32;
	localparam int CH_W       = 8;
	localparam int CH_N       = 3;
	localparam int MODE_W     = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;
	localparam int IN_TDATA_W = 24;

	// gradient arithmetic: |end-start| * offset / divisor, quotient fits a channel
	localparam int OFF_W     = SIZE_W;
	localparam int NUM_W     = CH_W + OFF_W;
	localparam int QUO_W     = CH_W;
	localparam int DIV_STEPS = QUO_W;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_RECT_X      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RECT_Y      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RECT_W      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RECT_H      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_COLOR_START = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_COLOR_END   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_FILL_MODE   = 3'd6;

	// fill modes; the unused code falls back to solid
	localparam logic [MODE_W-1:0] FILL_SOLID = 2'd0;
	localparam logic [MODE_W-1:0] FILL_VERT  = 2'd1;
	localparam logic [MODE_W-1:0] FILL_HORZ  = 2'd2;

	localparam logic [CH_W-1:0] ALPHA_OPAQUE = 8'hFF;

	// per-stage load enables of the quotient pipeline
	typedef logic [DIV_STEPS-1:0] div_en_t;

	// side info that rides along with each pixel
	typedef struct packed {
		logic hit;
		logic grad;
	} px_tag_t;

endpackage

@@ sv/rect_gradient_pixel_shader_core.sv @@
// Rectangle fill pixel shader: inside test plus solid or linear gradient color.
// Depends on rgps_pkg and rgps_div (one instance per color channel).
//
//   channel   signals                      beat contents (low bit first)
//   pixel in  s_tvalid s_tready s_tdata    pixel_x[10:0], pixel_y[21:11], zero pad
//   color out m_tvalid m_tready m_tdata    pixel_color[31:0]
//             m_tuser                      inside_res
//   config    cfg_we cfg_idx cfg_wdata     register write, no read-back
//
// Throughput one pixel per clock while m_tready does not hold the output back.
// The quotient pipeline has 8 stages, one quotient bit each; it comes after
// a qualify stage and a multiply stage, and before the output register.
// Each stage loads when empty or when the stage after it moves, so bubbles close
// up and a stalled output still lets input fill the pipe until every stage is full.
// arst_n clears the valid bits and the configuration registers; no clearing pass.
// Registers must be written only while no pixel is in flight.
module rect_gradient_pixel_shader_core
	import rgps_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,

	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_TDATA_W-1:0] s_tdata,	// pixel_x[10:0], pixel_y[21:11]

	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [ARGB_W-1:0]     m_tdata,	// pixel_color[31:0]
	output logic                  m_tuser,	// inside_res[0]

	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	// ---------------- configuration registers ----------------
	logic signed [POS_W-1:0] rect_x_q, rect_y_q;
	logic [SIZE_W-1:0]       rect_w_q, rect_h_q;
	logic [RGB_W-1:0]        color_start_q, color_end_q;
	logic [MODE_W-1:0]       fill_mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rect_x_q      <= '0;
			rect_y_q      <= '0;
			rect_w_q      <= '0;
			rect_h_q      <= '0;
			color_start_q <= '0;
			color_end_q   <= '0;
			fill_mode_q   <= FILL_SOLID;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_RECT_X:      rect_x_q      <= cfg_wdata[POS_W-1:0];
				REG_RECT_Y:      rect_y_q      <= cfg_wdata[POS_W-1:0];
				REG_RECT_W:      rect_w_q      <= cfg_wdata[SIZE_W-1:0];
				REG_RECT_H:      rect_h_q      <= cfg_wdata[SIZE_W-1:0];
				REG_COLOR_START: color_start_q <= cfg_wdata[RGB_W-1:0];
				REG_COLOR_END:   color_end_q   <= cfg_wdata[RGB_W-1:0];
				REG_FILL_MODE:   fill_mode_q   <= cfg_wdata[MODE_W-1:0];
				default: ;	// unmapped index, write dropped
			endcase
		end
	end

	// ---------------- pipeline control ----------------
	logic    v_s1, v_s2, v_s11;
	logic    vd_s [DIV_STEPS];
	px_tag_t tag_s1, tag_s2, tag_s11;
	px_tag_t tagd_s [DIV_STEPS];

	logic    ld_s1, ld_s2, ld_s11;
	div_en_t ld_d;

	// load chain from the output back to the input
	always_comb begin
		ld_s11 = !v_s11 || m_tready;
		ld_d[DIV_STEPS-1] = !vd_s[DIV_STEPS-1] || ld_s11;
		for (int k = DIV_STEPS - 2; k >= 0; k--) begin
			ld_d[k] = !vd_s[k] || ld_d[k+1];
		end
		ld_s2 = !v_s2 || ld_d[0];
		ld_s1 = !v_s1 || ld_s2;
	end

	assign s_tready = ld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s11 <= 1'b0;
			for (int k = 0; k < DIV_STEPS; k++) begin
				vd_s[k] <= 1'b0;
			end
		end else begin
			if (ld_s1) v_s1 <= s_tvalid;
			if (ld_s2) v_s2 <= v_s1;
			if (ld_d[0]) vd_s[0] <= v_s2;
			for (int k = 1; k < DIV_STEPS; k++) begin
				if (ld_d[k]) vd_s[k] <= vd_s[k-1];
			end
			if (ld_s11) v_s11 <= vd_s[DIV_STEPS-1];
		end
	end

	// ---------------- stage 1: inside test, offset and divisor ----------------
	logic [COORD_W-1:0]  pix_x, pix_y;
	logic signed [17:0]  px_e, py_e, x0_e, y0_e, x1_e, y1_e, xoff, yoff;
	logic                on_screen, in_rect, grad_c;
	logic [SIZE_W-1:0]   span;
	logic [OFF_W-1:0]    off_c, den_c;
	logic [OFF_W-1:0]    off_s1, den_s1;

	assign pix_x = s_tdata[COORD_W-1:0];
	assign pix_y = s_tdata[2*COORD_W-1:COORD_W];

	always_comb begin
		px_e = signed'(18'(pix_x));
		py_e = signed'(18'(pix_y));
		x0_e = 18'(rect_x_q);
		y0_e = 18'(rect_y_q);
		x1_e = x0_e + signed'(18'(rect_w_q));
		y1_e = y0_e + signed'(18'(rect_h_q));
		xoff = px_e - x0_e;
		yoff = py_e - y0_e;

		on_screen = (SCR_CW'(pix_x) < SCR_CW'(SCREEN_WIDTH)) &&
			(SCR_CW'(pix_y) < SCR_CW'(SCREEN_HEIGHT));
		in_rect = (rect_w_q != '0) && (rect_h_q != '0) &&
			(px_e >= x0_e) && (px_e < x1_e) && (py_e >= y0_e) && (py_e < y1_e);

		grad_c = (fill_mode_q == FILL_VERT) || (fill_mode_q == FILL_HORZ);
		if (fill_mode_q == FILL_VERT) begin
			off_c = yoff[OFF_W-1:0];
			span  = rect_h_q;
		end else begin
			off_c = xoff[OFF_W-1:0];
			span  = rect_w_q;
		end
		// a span of one row or column divides by one
		den_c = (span > SIZE_W'(1)) ? OFF_W'(span - SIZE_W'(1)) : OFF_W'(1);
	end

	always_ff @(posedge clk) begin
		if (ld_s1) begin
			tag_s1.hit  <= on_screen && in_rect;
			tag_s1.grad <= grad_c;
			off_s1      <= off_c;
			den_s1      <= den_c;
		end
	end

	// ---------------- stage 2: |end - start| * offset per channel ----------------
	logic [NUM_W-1:0] num_s2 [CH_N];
	logic             neg_s2 [CH_N];
	logic [OFF_W-1:0] den_s2;
	logic [CH_W-1:0]  ch_a [CH_N];
	logic [CH_W-1:0]  ch_b [CH_N];
	logic [CH_W-1:0]  mag_c [CH_N];
	logic             neg_c [CH_N];

	always_comb begin
		for (int c = 0; c < CH_N; c++) begin
			ch_a[c]  = color_start_q[c*CH_W +: CH_W];
			ch_b[c]  = color_end_q[c*CH_W +: CH_W];
			neg_c[c] = ch_b[c] < ch_a[c];
			mag_c[c] = neg_c[c] ? (ch_a[c] - ch_b[c]) : (ch_b[c] - ch_a[c]);
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s2) begin
			tag_s2 <= tag_s1;
			den_s2 <= den_s1;
			for (int c = 0; c < CH_N; c++) begin
				num_s2[c] <= NUM_W'(mag_c[c]) * NUM_W'(off_s1);
				neg_s2[c] <= neg_c[c];
			end
		end
	end

	// ---------------- stages 3..10: quotient pipeline ----------------
	logic [QUO_W-1:0] quot [CH_N];

	for (genvar c = 0; c < CH_N; c++) begin : g_ch
		rgps_div u_div (
			.clk  (clk),
			.en   (ld_d),
			.num  (num_s2[c]),
			.den  (den_s2),
			.neg  (neg_s2[c]),
			.quot (quot[c])
		);
	end

	always_ff @(posedge clk) begin
		if (ld_d[0]) tagd_s[0] <= tag_s2;
		for (int k = 1; k < DIV_STEPS; k++) begin
			if (ld_d[k]) tagd_s[k] <= tagd_s[k-1];
		end
	end

	// ---------------- stage 11: start + quotient, alpha, output register ----------------
	logic [RGB_W-1:0]  rgb_c;
	logic [ARGB_W-1:0] color_s11;

	always_comb begin
		if (tagd_s[DIV_STEPS-1].grad) begin
			for (int c = 0; c < CH_N; c++) begin
				rgb_c[c*CH_W +: CH_W] = ch_a[c] + quot[c];
			end
		end else begin
			rgb_c = color_start_q;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s11) begin
			tag_s11   <= tagd_s[DIV_STEPS-1];
			color_s11 <= tagd_s[DIV_STEPS-1].hit ? {ALPHA_OPAQUE, rgb_c} : '0;
		end
	end

	assign m_tvalid = v_s11;
	assign m_tdata  = color_s11;
	assign m_tuser  = tag_s11.hit;

`ifndef NO_ASSERTIONS
	a_outside_black: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> (m_tdata == '0))
		else $error("outside pixel with nonzero color");

	a_inside_opaque: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata[ARGB_W-1:RGB_W] == ALPHA_OPAQUE))
		else $error("inside pixel without opaque alpha");

	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> v_s1)
		else $error("accepted beat not held in first stage");

	a_stall_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		(vd_s[DIV_STEPS-1] && !ld_s11) |=> vd_s[DIV_STEPS-1])
		else $error("last quotient stage dropped a pixel under stall");

	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (v_s1 && v_s2 && v_s11))
		else $error("input stalled with a hole in the pipeline");
`endif

endmodule

@@ sv/rgps_div.sv @@
// Pipelined restoring divider for one color channel, one quotient bit per stage.
// Depends on rgps_pkg; the stage load enables come from the top level.
module rgps_div
	import rgps_pkg::*;
(
	input  logic             clk,
	input  div_en_t          en,
	input  logic [NUM_W-1:0] num,	// magnitude of (end - start) * offset
	input  logic [OFF_W-1:0] den,
	input  logic             neg,
	output logic [QUO_W-1:0] quot	// signed quotient, two's complement
);

	logic [NUM_W-1:0] rem_s [DIV_STEPS];
	logic [QUO_W-1:0] q_s   [DIV_STEPS];
	logic [OFF_W-1:0] den_s [DIV_STEPS];
	logic             neg_s [DIV_STEPS];

	logic [NUM_W-1:0] src_rem [DIV_STEPS];
	logic [QUO_W-1:0] src_q   [DIV_STEPS];
	logic [OFF_W-1:0] src_den [DIV_STEPS];
	logic             src_neg [DIV_STEPS];
	logic [NUM_W:0]   trial   [DIV_STEPS];
	logic [NUM_W-1:0] nxt_rem [DIV_STEPS];
	logic [QUO_W-1:0] nxt_q   [DIV_STEPS];

	always_comb begin
		src_rem[0] = num;
		src_q[0]   = '0;
		src_den[0] = den;
		src_neg[0] = neg;
		for (int k = 1; k < DIV_STEPS; k++) begin
			src_rem[k] = rem_s[k-1];
			src_q[k]   = q_s[k-1];
			src_den[k] = den_s[k-1];
			src_neg[k] = neg_s[k-1];
		end
		for (int k = 0; k < DIV_STEPS; k++) begin
			// stage k decides quotient bit DIV_STEPS-1-k
			trial[k] = {1'b0, src_rem[k]} -
				((NUM_W+1)'(src_den[k]) << (DIV_STEPS - 1 - k));
			nxt_q[k] = src_q[k];
			if (!trial[k][NUM_W]) begin
				nxt_rem[k] = trial[k][NUM_W-1:0];
				nxt_q[k][DIV_STEPS-1-k] = 1'b1;
			end else begin
				nxt_rem[k] = src_rem[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < DIV_STEPS; k++) begin
			if (en[k]) begin
				rem_s[k] <= nxt_rem[k];
				q_s[k]   <= nxt_q[k];
				den_s[k] <= src_den[k];
				neg_s[k] <= src_neg[k];
			end
		end
	end

	assign quot = neg_s[DIV_STEPS-1] ? (QUO_W'(0) - q_s[DIV_STEPS-1]) : q_s[DIV_STEPS-1];

endmodule
